>>> rtl/mpi_pkg.sv
// ----------------------------------------------------------------------------
// mpi_pkg: shared types and constants for the missing pulse injector
// Field widths, packet kind codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package mpi_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;

    localparam int KIND_W     = 2;
    localparam int SEC_W      = 32;
    localparam int NANO_W     = 32;
    localparam int STAMP_W    = SEC_W + NANO_W;
    localparam int HANDLE_W   = 16;
    localparam int LIMIT_W    = 5;
    localparam int SKIP_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_OTHER  = 2'd0,
        KIND_TIMING = 2'd1,
        KIND_DATA   = 2'd2
    } pkt_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE = 2'd0,
        CFG_LIMIT  = 2'd1,
        CFG_SKIP   = 2'd2
    } cfg_index_t;

    localparam logic              ENABLE_RESET = 1'b0;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd10;
    localparam logic [SKIP_W-1:0]  SKIP_RESET  = 8'd0;

endpackage

>>> rtl/mpi_item_if.sv
// ----------------------------------------------------------------------------
// mpi_item_if: packet descriptor channel
// valid/ready handshake carrying one packet descriptor per item.
// ----------------------------------------------------------------------------
interface mpi_item_if import mpi_pkg::*;;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   packet_kind;
    logic                has_timing;
    logic [SEC_W-1:0]    stamp_seconds;
    logic [NANO_W-1:0]   stamp_nanos;
    logic [HANDLE_W-1:0] packet_handle;

    modport source (
        output valid, packet_kind, has_timing, stamp_seconds, stamp_nanos, packet_handle,
        input  ready
    );
    modport sink (
        input  valid, packet_kind, has_timing, stamp_seconds, stamp_nanos, packet_handle,
        output ready
    );
endinterface

>>> rtl/mpi_result_if.sv
// ----------------------------------------------------------------------------
// mpi_result_if: result channel
// valid/ready handshake carrying one injected pulse or passed packet per item.
// ----------------------------------------------------------------------------
interface mpi_result_if import mpi_pkg::*;;
    logic                valid;
    logic                ready;
    logic                injected;
    logic [SEC_W-1:0]    out_seconds;
    logic [NANO_W-1:0]   out_nanos;
    logic [HANDLE_W-1:0] out_handle;
    logic                last_result;

    modport source (
        output valid, injected, out_seconds, out_nanos, out_handle, last_result,
        input  ready
    );
    modport sink (
        input  valid, injected, out_seconds, out_nanos, out_handle, last_result,
        output ready
    );
endinterface

>>> rtl/mpi_cfg_if.sv
// ----------------------------------------------------------------------------
// mpi_cfg_if: configuration write channel
// valid/ready handshake carrying a register index and write data.
// ----------------------------------------------------------------------------
interface mpi_cfg_if import mpi_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] write_data;

    modport source (
        output valid, reg_index, write_data,
        input  ready
    );
    modport sink (
        input  valid, reg_index, write_data,
        output ready
    );
endinterface

>>> rtl/mpi_stamp_store.sv
// ----------------------------------------------------------------------------
// mpi_stamp_store: timestamp queue storage
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module mpi_stamp_store
    import mpi_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rd_en,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
    output logic [STAMP_W-1:0]             rd_data,
    input  logic                           wr_en,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
    input  logic [STAMP_W-1:0]             wr_data
);

    logic [STAMP_W-1:0] mem [QUEUE_DEPTH];
    logic [STAMP_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/missing_pulse_injector_core.sv
// ----------------------------------------------------------------------------
// missing_pulse_injector_core: empty pulse injection for a packet stream
// Tracks queued timing stamps and injects empty pulses for skipped ones.
// ----------------------------------------------------------------------------
// Usage:
//   pkt  - packet descriptors in (valid/ready). One item at a time; ready is
//          low while an item is being worked on.
//   res  - results out (valid/ready). Each packet gives zero or more injected
//          pulses followed by the packet itself, flagged by last_result.
//   cfg  - register writes (always ready); write only while idle.
// Sequence: a packet that only passes through goes IDLE, PASS, back to IDLE
//   before the next can be accepted. A timing packet adds a tail compare
//   (LOOK, CHECK) if the queue is not empty, then APPEND unless the tail matches.
//   A data packet searches, then drains skipped entries, one LOOK/CHECK per entry
//   with one shared 64-bit compare and one storage read port per step.
// The result sits in an output register, so the next packet is accepted
//   while the last result of the previous one waits. A stalled receiver
//   holds the sequencer only when it has a new result to present.
// Reset clears pointers and state, loads config reset values; storage is not cleared.
// ----------------------------------------------------------------------------
module missing_pulse_injector_core
    import mpi_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    mpi_item_if.sink     pkt,
    mpi_result_if.source res,
    mpi_cfg_if.sink      cfg
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int CMP_W = (CNT_W + 1 > LIMIT_W) ? CNT_W + 1 : LIMIT_W;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LOOK   = 5'b00010,
        ST_CHECK  = 5'b00100,
        ST_APPEND = 5'b01000,
        ST_PASS   = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        MODE_TAIL   = 2'd0,
        MODE_SEARCH = 2'd1,
        MODE_DRAIN  = 2'd2
    } mode_t;

    state_t               state_reg, state_next;
    mode_t                mode_reg, mode_next;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     pos_reg, pos_next;
    logic [SKIP_W-1:0]    remain_reg, remain_next;

    logic                 enable_reg;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [SKIP_W-1:0]    skip_reg;

    logic [SEC_W-1:0]     sec_reg;
    logic [NANO_W-1:0]    nanos_reg;
    logic [HANDLE_W-1:0]  handle_reg;

    logic                 res_valid_reg, res_valid_next;
    logic                 res_inj_reg;
    logic [SEC_W-1:0]     res_sec_reg;
    logic [NANO_W-1:0]    res_nanos_reg;
    logic [HANDLE_W-1:0]  res_handle_reg;
    logic                 res_last_reg;

    logic                 load_inj;
    logic                 load_pass;
    logic                 out_free;
    logic                 stamp_match;
    logic                 rd_en;
    logic                 wr_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W-1:0]     wr_addr;
    logic [STAMP_W-1:0]   rd_data;
    logic [CMP_W-1:0]     grown_count;

    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(off);
        if (s >= SUM_W'(QUEUE_DEPTH))
        begin
            s = s - SUM_W'(QUEUE_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    mpi_stamp_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({sec_reg, nanos_reg})
    );

    assign pkt.ready   = (state_reg == ST_IDLE);
    assign cfg.ready   = 1'b1;
    assign out_free    = !res_valid_reg || res.ready;
    assign stamp_match = (rd_data == {sec_reg, nanos_reg});
    assign rd_en       = (state_reg == ST_LOOK);
    assign wr_en       = (state_reg == ST_APPEND);
    assign rd_addr     = wrap_add(head_reg, (mode_reg == MODE_DRAIN) ? '0 : pos_reg);
    assign wr_addr     = wrap_add(head_reg, count_reg);
    assign grown_count = CMP_W'(count_reg) + CMP_W'(1);

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        remain_next = remain_reg;
        load_inj    = 1'b0;
        load_pass   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pkt.valid)
                begin
                    if (enable_reg && pkt.has_timing && pkt.packet_kind == KIND_TIMING)
                    begin
                        if (count_reg == '0)
                        begin
                            state_next = ST_APPEND;
                        end
                        else
                        begin
                            mode_next  = MODE_TAIL;
                            pos_next   = count_reg - CNT_W'(1);
                            state_next = ST_LOOK;
                        end
                    end
                    else if (enable_reg && pkt.has_timing && pkt.packet_kind == KIND_DATA
                             && count_reg != '0)
                    begin
                        mode_next  = MODE_SEARCH;
                        pos_next   = '0;
                        state_next = ST_LOOK;
                    end
                    else
                    begin
                        state_next = ST_PASS;
                    end
                end
            end

            ST_LOOK:
            begin
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                case (mode_reg)
                    MODE_TAIL:
                    begin
                        state_next = stamp_match ? ST_PASS : ST_APPEND;
                    end
                    MODE_SEARCH:
                    begin
                        if (stamp_match)
                        begin
                            if (pos_reg == '0)
                            begin
                                state_next = ST_PASS;
                            end
                            else
                            begin
                                // retire the head; pos now counts entries left to drain
                                head_next   = wrap_add(head_reg, CNT_W'(1));
                                count_next  = count_reg - CNT_W'(1);
                                remain_next = skip_reg;
                                pos_next    = pos_reg - CNT_W'(1);
                                mode_next   = MODE_DRAIN;
                                state_next  = (pos_reg == CNT_W'(1)) ? ST_PASS : ST_LOOK;
                            end
                        end
                        else if (pos_reg + CNT_W'(1) == count_reg)
                        begin
                            state_next = ST_PASS;
                        end
                        else
                        begin
                            pos_next   = pos_reg + CNT_W'(1);
                            state_next = ST_LOOK;
                        end
                    end
                    MODE_DRAIN:
                    begin
                        if (remain_reg != '0 || out_free)
                        begin
                            if (remain_reg == '0)
                            begin
                                load_inj    = 1'b1;
                                remain_next = skip_reg;
                            end
                            else
                            begin
                                remain_next = remain_reg - SKIP_W'(1);
                            end
                            head_next  = wrap_add(head_reg, CNT_W'(1));
                            count_next = count_reg - CNT_W'(1);
                            pos_next   = pos_reg - CNT_W'(1);
                            state_next = (pos_reg == CNT_W'(1)) ? ST_PASS : ST_LOOK;
                        end
                    end
                    default:
                    begin
                        state_next = ST_PASS;
                    end
                endcase
            end

            ST_APPEND:
            begin
                if (count_reg == CNT_W'(QUEUE_DEPTH))
                begin
                    head_next = wrap_add(head_reg, CNT_W'(1));
                end
                else if (grown_count > CMP_W'(limit_reg))
                begin
                    // over the limit: oldest entry goes, count stays
                    head_next = wrap_add(head_reg, CNT_W'(1));
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = ST_PASS;
            end

            ST_PASS:
            begin
                if (out_free)
                begin
                    load_pass  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_inj || load_pass)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_TAIL;
            head_reg      <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            remain_reg    <= '0;
            res_valid_reg <= 1'b0;
            enable_reg    <= ENABLE_RESET;
            limit_reg     <= LIMIT_RESET;
            skip_reg      <= SKIP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            remain_reg    <= remain_next;
            res_valid_reg <= res_valid_next;
            if (cfg.valid)
            begin
                case (cfg.reg_index)
                    CFG_ENABLE: enable_reg <= cfg.write_data[0];
                    CFG_LIMIT:  limit_reg  <= cfg.write_data[LIMIT_W-1:0];
                    CFG_SKIP:   skip_reg   <= cfg.write_data[SKIP_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (pkt.valid && pkt.ready)
        begin
            sec_reg    <= pkt.stamp_seconds;
            nanos_reg  <= pkt.stamp_nanos;
            handle_reg <= pkt.packet_handle;
        end
        if (load_inj)
        begin
            res_inj_reg    <= 1'b1;
            res_sec_reg    <= rd_data[STAMP_W-1:NANO_W];
            res_nanos_reg  <= rd_data[NANO_W-1:0];
            res_handle_reg <= '0;
            res_last_reg   <= 1'b0;
        end
        else if (load_pass)
        begin
            res_inj_reg    <= 1'b0;
            res_sec_reg    <= sec_reg;
            res_nanos_reg  <= nanos_reg;
            res_handle_reg <= handle_reg;
            res_last_reg   <= 1'b1;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.injected    = res_inj_reg;
    assign res.out_seconds = res_sec_reg;
    assign res.out_nanos   = res_nanos_reg;
    assign res.out_handle  = res_handle_reg;
    assign res.last_result = res_last_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, head_reg} < (IDX_W + 1)'(QUEUE_DEPTH))
        else $error("queue head out of range");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        pkt.valid && pkt.ready |=> !pkt.ready)
        else $error("item accepted while previous one in flight");

    a_injected_form: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.injected |-> !res.last_result && res.out_handle == '0)
        else $error("injected pulse flagged last or carries a handle");
`endif

endmodule

>>> tb/tb_missing_pulse_injector_core.sv
// ----------------------------------------------------------------------------
// tb_missing_pulse_injector_core: self-checking bench for the pulse injector
// Drives packet descriptors with random gaps, stalls the result side at random,
// and checks every result against a cycle-free model of the stamp queue.
// A directed opener covers the corner cases, then eleven random phases sweep
// enable, queue limit (zero, small, saturating) and skip count.
// ----------------------------------------------------------------------------
module tb_missing_pulse_injector_core;
    import mpi_pkg::*;

    localparam int QDEPTH        = DEF_QUEUE_DEPTH;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 4 * QDEPTH + 16;
    localparam int HISTORY_LEN   = 20;

    // encodings the package leaves unnamed
    localparam logic [KIND_W-1:0]    KIND_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic                has_timing;
        logic [SEC_W-1:0]    seconds;
        logic [NANO_W-1:0]   nanos;
        logic [HANDLE_W-1:0] handle;
        int unsigned         gap;
    } packet_t;

    typedef struct {
        logic                injected;
        logic [SEC_W-1:0]    seconds;
        logic [NANO_W-1:0]   nanos;
        logic [HANDLE_W-1:0] handle;
        logic                last;
    } pulse_result_t;

    typedef struct {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } reg_write_t;

    logic clk;
    logic rst_n;

    mpi_item_if   pkt_ch ();
    mpi_result_if res_ch ();
    mpi_cfg_if    cfg_ch ();

    missing_pulse_injector_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    packet_t            send_queue[$];
    reg_write_t         reg_queue[$];
    pulse_result_t      expected_out[$];
    logic [STAMP_W-1:0] stamp_history[$];
    logic [STAMP_W-1:0] pulse_clock;

    int unsigned gap_max;
    int unsigned stall_max;
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned cycle_count = 0;
    int unsigned error_count = 0;

    // shadow of the block's stamp queue and registers
    logic [STAMP_W-1:0]  shadow_stamps [QDEPTH];
    logic [3:0]          shadow_head;
    logic [4:0]          shadow_count;
    logic                shadow_enable;
    logic [LIMIT_W-1:0]  shadow_limit;
    logic [SKIP_W-1:0]   shadow_skip;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_missing_pulse_injector_core: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Queue model
    // ------------------------------------------------------------------------
    function automatic logic [STAMP_W-1:0] shadow_entry(int pos);
        return shadow_stamps[(int'(shadow_head) + pos) % QDEPTH];
    endfunction

    task automatic shadow_drop();
        if (shadow_count != 0)
        begin
            shadow_head  = 4'((int'(shadow_head) + 1) % QDEPTH);
            shadow_count = shadow_count - 5'd1;
        end
    endtask

    task automatic shadow_append(logic [STAMP_W-1:0] stamp);
        int lim;
        lim = (int'(shadow_limit) > QDEPTH) ? QDEPTH : int'(shadow_limit);
        // full storage drops before the write, otherwise the limit trims after
        if (int'(shadow_count) >= QDEPTH)
        begin
            shadow_drop();
            shadow_stamps[(int'(shadow_head) + int'(shadow_count)) % QDEPTH] = stamp;
            shadow_count = shadow_count + 5'd1;
        end
        else
        begin
            shadow_stamps[(int'(shadow_head) + int'(shadow_count)) % QDEPTH] = stamp;
            shadow_count = shadow_count + 5'd1;
            if (int'(shadow_count) > lim)
                shadow_drop();
        end
    endtask

    task automatic push_expect(logic inj, logic [STAMP_W-1:0] stamp,
                               logic [HANDLE_W-1:0] handle, logic last);
        pulse_result_t r;
        r.injected = inj;
        r.seconds  = stamp[STAMP_W-1:NANO_W];
        r.nanos    = stamp[NANO_W-1:0];
        r.handle   = handle;
        r.last     = last;
        expected_out.insert(expected_out.size(), r);
    endtask

    task automatic predict_outputs(logic [KIND_W-1:0] kind, logic timed,
                                   logic [STAMP_W-1:0] stamp, logic [HANDLE_W-1:0] handle);
        int hit;
        logic [SKIP_W-1:0] remain;
        hit = -1;
        if (shadow_enable)
        begin
            if (kind == KIND_TIMING && timed)
            begin
                if (shadow_count == 0 || shadow_entry(int'(shadow_count) - 1) != stamp)
                    shadow_append(stamp);
            end
            else if (kind == KIND_DATA && timed)
            begin
                for (int i = 0; i < int'(shadow_count); i++)
                begin
                    if (shadow_entry(i) == stamp)
                    begin
                        hit = i;
                        break;
                    end
                end
                // a match past the head retires everything in front of it
                if (hit > 0)
                begin
                    remain = shadow_skip;
                    shadow_drop();
                    while (shadow_count != 0 && shadow_entry(0) != stamp)
                    begin
                        if (remain == 0)
                        begin
                            push_expect(1'b1, shadow_entry(0), '0, 1'b0);
                            remain = shadow_skip;
                        end
                        else
                            remain = remain - SKIP_W'(1);
                        shadow_drop();
                    end
                end
            end
        end
        push_expect(1'b0, stamp, handle, 1'b1);
    endtask

    function automatic bit field_ok(string name, logic [63:0] want, logic [63:0] got);
        if (want === got)
            return 1'b1;
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        packet_t nxt;
        if (!rst_n)
        begin
            pkt_ch.valid         <= 1'b0;
            pkt_ch.packet_kind   <= KIND_OTHER;
            pkt_ch.has_timing    <= 1'b0;
            pkt_ch.stamp_seconds <= '0;
            pkt_ch.stamp_nanos   <= '0;
            pkt_ch.packet_handle <= '0;
            gap_left             <= 0;
        end
        else if (!pkt_ch.valid || pkt_ch.ready)
        begin
            if (gap_left != 0)
            begin
                pkt_ch.valid <= 1'b0;
                gap_left     <= gap_left - 1;
            end
            else if (send_queue.size() != 0)
            begin
                nxt = send_queue[0];
                send_queue.delete(0);
                pkt_ch.valid         <= 1'b1;
                pkt_ch.packet_kind   <= nxt.kind;
                pkt_ch.has_timing    <= nxt.has_timing;
                pkt_ch.stamp_seconds <= nxt.seconds;
                pkt_ch.stamp_nanos   <= nxt.nanos;
                pkt_ch.packet_handle <= nxt.handle;
                gap_left             <= nxt.gap;
            end
            else
                pkt_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        reg_write_t w;
        if (!rst_n)
        begin
            cfg_ch.valid      <= 1'b0;
            cfg_ch.reg_index  <= CFG_ENABLE;
            cfg_ch.write_data <= '0;
        end
        else if (!cfg_ch.valid || cfg_ch.ready)
        begin
            if (reg_queue.size() != 0)
            begin
                w = reg_queue[0];
                reg_queue.delete(0);
                cfg_ch.valid      <= 1'b1;
                cfg_ch.reg_index  <= w.index;
                cfg_ch.write_data <= w.data;
            end
            else
                cfg_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: register writes and accepted packets feed the model, results
    // are checked in order, and the result ready is stalled at random.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        pulse_result_t want;
        bit ok;
        int unsigned pause;
        if (!rst_n)
        begin
            res_ch.ready  <= 1'b0;
            stall_left    <= 0;
            shadow_head   = '0;
            shadow_count  = '0;
            shadow_enable = ENABLE_RESET;
            shadow_limit  = LIMIT_RESET;
            shadow_skip   = SKIP_RESET;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.reg_index)
                    CFG_ENABLE: shadow_enable = cfg_ch.write_data[0];
                    CFG_LIMIT:  shadow_limit  = cfg_ch.write_data[LIMIT_W-1:0];
                    CFG_SKIP:   shadow_skip   = cfg_ch.write_data[SKIP_W-1:0];
                    default: ;
                endcase
            end

            if (pkt_ch.valid && pkt_ch.ready)
                predict_outputs(pkt_ch.packet_kind, pkt_ch.has_timing,
                                {pkt_ch.stamp_seconds, pkt_ch.stamp_nanos},
                                pkt_ch.packet_handle);

            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_out.size() == 0)
                begin
                    $display("%0t: unexpected result expected none got inj=%0d %h_%h h=%h",
                             $time, res_ch.injected, res_ch.out_seconds,
                             res_ch.out_nanos, res_ch.out_handle);
                    error_count = error_count + 1;
                end
                else
                begin
                    want = expected_out[0];
                    expected_out.delete(0);
                    ok = field_ok("injected", 64'(want.injected), 64'(res_ch.injected))
                       & field_ok("out_seconds", 64'(want.seconds), 64'(res_ch.out_seconds))
                       & field_ok("out_nanos", 64'(want.nanos), 64'(res_ch.out_nanos))
                       & field_ok("out_handle", 64'(want.handle), 64'(res_ch.out_handle))
                       & field_ok("last_result", 64'(want.last), 64'(res_ch.last_result));
                    if (!ok)
                        error_count = error_count + 1;
                end
                pause = $urandom_range(0, stall_max);
                res_ch.ready <= (pause == 0);
                stall_left   <= (pause == 0) ? 0 : pause - 1;
            end
            else if (stall_left != 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left   <= stall_left - 1;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic queue_packet(logic [KIND_W-1:0] kind, logic timed,
                                logic [STAMP_W-1:0] stamp, logic [HANDLE_W-1:0] handle);
        packet_t p;
        p.kind       = kind;
        p.has_timing = timed;
        p.seconds    = stamp[STAMP_W-1:NANO_W];
        p.nanos      = stamp[NANO_W-1:0];
        p.handle     = handle;
        p.gap        = $urandom_range(0, gap_max);
        send_queue.insert(send_queue.size(), p);
    endtask

    task automatic set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        reg_write_t w;
        w.index = index;
        w.data  = data;
        reg_queue.insert(reg_queue.size(), w);
    endtask

    // everything sent, every result back, then a quiet settle wait
    task automatic wait_idle();
        do
            @(negedge clk);
        while (send_queue.size() != 0 || reg_queue.size() != 0 || pkt_ch.valid
               || cfg_ch.valid || expected_out.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic configure(logic en, int lim, int skip);
        logic [CFG_DATA_W-1:0] data;
        wait_idle();
        // unused upper data bits carry noise
        data    = CFG_DATA_W'($urandom);
        data[0] = en;
        set_register(CFG_ENABLE, data);
        data = CFG_DATA_W'($urandom);
        data[LIMIT_W-1:0] = LIMIT_W'(lim);
        set_register(CFG_LIMIT, data);
        set_register(CFG_SKIP, CFG_DATA_W'(skip));
        wait_idle();
    endtask

    function automatic logic [STAMP_W-1:0] next_pulse_stamp();
        pulse_clock = pulse_clock + STAMP_W'($urandom_range(1, 1 << 20));
        if ($urandom_range(0, 3) == 0)
            pulse_clock = pulse_clock + {32'd1, 32'd0};
        return pulse_clock;
    endfunction

    // mostly well-formed pulse trains: new timing stamps and data packets that
    // hit a recent stamp, plus repeats, near misses and random noise
    task automatic run_phase(logic en, int lim, int skip, int gaps, int stalls,
                             int count, bit mid_pause);
        int sel;
        logic [STAMP_W-1:0] st;
        configure(en, lim, skip);
        gap_max   = gaps;
        stall_max = stalls;
        for (int k = 0; k < count; k++)
        begin
            if (mid_pause && k == count / 2)
                wait_idle();
            sel = $urandom_range(0, 99);
            if (sel < 45 || stamp_history.size() == 0)
            begin
                st = next_pulse_stamp();
                stamp_history.insert(stamp_history.size(), st);
                if (stamp_history.size() > HISTORY_LEN)
                    stamp_history.delete(0);
                queue_packet(KIND_TIMING, 1'b1, st, HANDLE_W'($urandom));
            end
            else if (sel < 72)
            begin
                st = stamp_history[$urandom_range(0, stamp_history.size() - 1)];
                queue_packet(KIND_DATA, 1'b1, st, HANDLE_W'($urandom));
            end
            else if (sel < 78)
                queue_packet(KIND_TIMING, 1'b1, stamp_history[$], HANDLE_W'($urandom));
            else if (sel < 85)
            begin
                st = stamp_history[$urandom_range(0, stamp_history.size() - 1)];
                st = st ^ (64'd1 << $urandom_range(0, STAMP_W - 1));
                queue_packet(KIND_DATA, 1'b1, st, HANDLE_W'($urandom));
            end
            else
                queue_packet(KIND_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                             {$urandom, $urandom}, HANDLE_W'($urandom));
        end
    endtask

    initial
    begin
        logic [STAMP_W-1:0] base;

        rst_n       = 1'b0;
        gap_max     = 3;
        stall_max   = 3;
        pulse_clock = {$urandom, $urandom};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: injection off, everything passes
        base = {$urandom, $urandom};
        queue_packet(KIND_TIMING, 1'b1, '1, '1);
        queue_packet(KIND_DATA, 1'b1, '0, '0);
        queue_packet(KIND_SPARE, 1'b1, base, HANDLE_W'($urandom));
        queue_packet(KIND_OTHER, 1'b0, base + 9, HANDLE_W'($urandom));

        configure(1'b1, 4, 0);
        queue_packet(KIND_DATA, 1'b1, base + 1, 16'h0001);     // empty queue, no match
        queue_packet(KIND_TIMING, 1'b1, base + 1, 16'h0002);   // empty queue takes it
        queue_packet(KIND_TIMING, 1'b1, base + 1, 16'h0003);   // same as newest
        queue_packet(KIND_TIMING, 1'b0, base + 9, 16'h0004);   // no stamp
        queue_packet(KIND_TIMING, 1'b1, base + 2, 16'h0005);
        queue_packet(KIND_TIMING, 1'b1, base + 3, 16'h0006);
        queue_packet(KIND_TIMING, 1'b1, base + 4, 16'h0007);
        queue_packet(KIND_DATA, 1'b1, base + 1, 16'h0008);     // hits the head
        queue_packet(KIND_DATA, 1'b1, base + 3, 16'h0009);     // one pulse injected
        queue_packet(KIND_TIMING, 1'b1, base + 5, 16'h000a);
        queue_packet(KIND_TIMING, 1'b1, base + 6, 16'h000b);
        queue_packet(KIND_TIMING, 1'b1, base + 7, 16'h000c);   // over the limit
        queue_packet(KIND_DATA, 1'b0, base + 7, 16'h000d);     // no stamp
        queue_packet(KIND_DATA, 1'b1, base + 7, 16'h000e);     // two pulses injected
        queue_packet(KIND_DATA, 1'b1, (base + 7) ^ {32'd1, 32'd0}, 16'h000f);
        queue_packet(KIND_TIMING, 1'b1, '1, 16'hfffe);
        queue_packet(KIND_TIMING, 1'b1, '0, 16'h0010);
        queue_packet(KIND_DATA, 1'b1, '0, 16'h0011);
        queue_packet(KIND_OTHER, 1'b1, base + 8, 16'h0012);

        run_phase(1'b1, 16, 0, 0, 0, 50, 1'b1);
        run_phase(1'b1, 16, 1, 8, 8, 45, 1'b0);
        run_phase(1'b1, 31, 2, 8, 0, 45, 1'b0);    // limit saturates at depth
        run_phase(1'b1, 3, 0, 0, 8, 35, 1'b0);     // limit now under the count
        run_phase(1'b1, 0, 0, 8, 8, 30, 1'b0);
        run_phase(1'b1, 1, 0, 0, 0, 25, 1'b0);
        wait_idle();
        set_register(CFG_UNUSED, CFG_DATA_W'($urandom));
        run_phase(1'b0, 10, 3, 8, 8, 30, 1'b0);
        run_phase(1'b1, 12, 255, 8, 8, 45, 1'b0);
        run_phase(1'b1, $urandom_range(0, 31), $urandom_range(0, 255), 8, 8, 40, 1'b0);
        run_phase(1'b1, 16, $urandom_range(0, 3), 3, 3, 45, 1'b0);
        run_phase(1'b1, 8, 0, 8, 8, 40, 1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0 && expected_out.size() == 0)
            $display("tb_missing_pulse_injector_core: clean");
        else
            $display("tb_missing_pulse_injector_core: errors");
        $finish;
    end

endmodule
